// ===== design/box_blur_3x3_rgba_macros.svh =====
// Assertion macros of the box blur RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BOX_BLUR_3X3_RGBA_MACROS_SVH
`define BOX_BLUR_3X3_RGBA_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BBLUR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bblur: invariant violated");

// A condition in one cycle that forces another in the next cycle.
`define BBLUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bblur: next-cycle check violated");

`endif

// ===== design/bblur_pkg.sv =====
// Types, constants and helper functions of the 3x3 box blur.
// Depends on nothing; used by every other design file but the macro header.
package bblur_pkg;

    localparam int PIXEL_W      = 32;
    localparam int RGB_W        = 24;
    localparam int CHAN_W       = 8;
    localparam int LINE_W       = 2 * RGB_W;
    localparam int SUM_W        = 12;
    localparam int SIZE_W       = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int DIV9_MUL     = 1821;
    localparam int DIV9_SHIFT   = 14;
    localparam int PROD_W       = SUM_W + SIZE_W;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd1024;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd768;
    localparam logic [CHAN_W-1:0] RST_ALPHA  = 8'hFF;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_ALPHA_VALUE  = 2'd2
    } bblur_reg_t;

    // Per-word control decided at the input side from the frame position.
    typedef struct packed {
        logic has_result;
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bot_ok;
        logic done;
    } bblur_ctl_t;

    // Channel sums of one finished neighbourhood.
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic             done;
    } bblur_sums_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int unsigned maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (32'(v) > maxv)
        begin
            r = SIZE_W'(maxv);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Exact floor(x / 9) for every sum of nine bytes (x below 2296).
    function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(DIV9_MUL);
        return p[DIV9_SHIFT + CHAN_W - 1:DIV9_SHIFT];
    endfunction

endpackage

// ===== design/bblur_intf.sv =====
// Valid/ready channel interfaces of the box blur: pixel input, result output
// and configuration writes. Depends on bblur_pkg.
interface bblur_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [bblur_pkg::PIXEL_W-1:0] pixel_word;

    modport source (output valid, output cmd, output pixel_word, input ready);
    modport sink   (input valid, input cmd, input pixel_word, output ready);
endinterface

interface bblur_out_if;
    logic                         valid;
    logic                         ready;
    logic [bblur_pkg::PIXEL_W-1:0] out_pixel;
    logic                         frame_done;

    modport source (output valid, output out_pixel, output frame_done, input ready);
    modport sink   (input valid, input out_pixel, input frame_done, output ready);
endinterface

interface bblur_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bblur_pkg::CFG_IDX_W-1:0]  index;
    logic [bblur_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/box_blur_3x3_rgba.sv =====
// Top level of the 3x3 RGBA box blur: input position logic, line store,
// window stage and the divide-by-nine output register.
// Depends on bblur_pkg, bblur_intf and all bblur_* modules.
//
// Usage:
//   pixels  : valid/ready input; cmd selects a pixel word or a drain step.
//             Words arrive in raster order, frame_width per row.
//   results : valid/ready output; out_pixel is the blurred RGB with the
//             configured alpha, frame_done marks the last pixel of a frame.
//   cfg     : valid/ready register writes (index, data), always ready.
//             Writing the width or height restarts the frame position.
// The result for pixel k is due with input word k + frame_width + 1 and reaches
// results through the sum stage and the output register. Drain steps flush the
// last row plus one pixel of each frame. Throughput is one word per cycle while
// results does not stall: the line store is read on acceptance and written back as
// the word leaves the line store stage, forwarding between back-to-back words on
// one column (width one, or a frame wrap). When results stalls, the output
// register, the sum stage and the line store stage fill before pixels.ready drops.
// Reset sets width 1024, height 768 (clamped to the maximum), alpha 255
// and empties the pipeline; line store contents are not cleared.
module box_blur_3x3_rgba #(
    parameter int MAX_WIDTH  = bblur_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bblur_pkg::DEF_MAX_HEIGHT
) (
    input  logic          clk,
    input  logic          rst_n,
    bblur_in_if.sink      pixels,
    bblur_out_if.source   results,
    bblur_cfg_if.sink     cfg
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                            acc;
    logic                            take_ok;
    logic                            out_free;
    bblur_pkg::bblur_ctl_t           ctl;
    bblur_pkg::bblur_sums_t          sums;
    logic [bblur_pkg::RGB_W-1:0]     pix;
    logic [AW-1:0]                   addr;
    logic [bblur_pkg::CHAN_W-1:0]    alpha;
    logic [bblur_pkg::LINE_W-1:0]    rd_data;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [bblur_pkg::LINE_W-1:0]    wr_data;

    logic                            out_valid_reg, out_valid_next;
    logic [bblur_pkg::PIXEL_W-1:0]   out_pixel_reg;
    logic                            out_done_reg;

    assign pixels.ready = take_ok;
    assign acc          = pixels.valid && take_ok;
    assign out_free     = !out_valid_reg || results.ready;

    bblur_cfg_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg_pos (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .acc        (acc),
        .cmd        (pixels.cmd),
        .pixel_word (pixels.pixel_word),
        .ctl        (ctl),
        .pix        (pix),
        .addr       (addr),
        .alpha      (alpha)
    );

    bblur_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (acc),
        .rd_addr (addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bblur_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .ctl_in   (ctl),
        .pix_in   (pix),
        .addr_in  (addr),
        .take_ok  (take_ok),
        .out_free (out_free),
        .sums     (sums),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (sums.valid && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sums.valid && out_free)
        begin
            out_pixel_reg <= {bblur_pkg::div9(sums.sum_r),
                              bblur_pkg::div9(sums.sum_g),
                              bblur_pkg::div9(sums.sum_b),
                              alpha};
            out_done_reg  <= sums.done;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_pixel  = out_pixel_reg;
    assign results.frame_done = out_done_reg;

endmodule

// ===== design/bblur_cfg_pos.sv =====
// Configuration registers and input-side frame position of the box blur.
// Decides per accepted word which neighbours exist and whether a result is due.
// Depends on bblur_pkg, bblur_intf and the assertion macro header.
`include "box_blur_3x3_rgba_macros.svh"

module bblur_cfg_pos #(
    parameter int MAX_WIDTH  = bblur_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bblur_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bblur_cfg_if.sink                         cfg,
    input  logic                              acc,
    input  logic                              cmd,
    input  logic [bblur_pkg::PIXEL_W-1:0]     pixel_word,
    output bblur_pkg::bblur_ctl_t             ctl,
    output logic [bblur_pkg::RGB_W-1:0]       pix,
    output logic [$clog2(MAX_WIDTH)-1:0]      addr,
    output logic [bblur_pkg::CHAN_W-1:0]      alpha
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [bblur_pkg::SIZE_W-1:0] width_reg, width_next;
    logic [bblur_pkg::SIZE_W-1:0] height_reg, height_next;
    logic [bblur_pkg::CHAN_W-1:0] alpha_reg, alpha_next;
    logic [CW-1:0]                col_reg, col_next;
    logic [RW-1:0]                row_reg, row_next;
    logic                         col_zero;
    logic [RW-1:0]                orow_plus1;
    logic                         cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;
    assign addr      = col_reg;
    assign alpha     = alpha_reg;

    assign col_zero   = (col_reg == '0);
    // Row below the output pixel; the output sits one row up and one column left.
    assign orow_plus1 = row_reg - RW'(col_zero);

    always_comb
    begin
        ctl.has_result = (32'(row_reg) >= 32'd2) || ((row_reg == RW'(1)) && !col_zero);
        ctl.left_ok    = col_zero ? (width_reg != bblur_pkg::SIZE_W'(1)) : (col_reg != CW'(1));
        ctl.right_ok   = !col_zero;
        ctl.top_ok     = col_zero ? (row_reg != RW'(2)) : (row_reg != RW'(1));
        ctl.bot_ok     = 32'(orow_plus1) < 32'(height_reg);
        ctl.done       = col_zero && (32'(row_reg) == 32'(height_reg) + 32'd1);
        if ((cmd == bblur_pkg::CMD_PIXEL) && (32'(row_reg) < 32'(height_reg)))
        begin
            pix = pixel_word[bblur_pkg::PIXEL_W-1:bblur_pkg::PIXEL_W-bblur_pkg::RGB_W];
        end
        else
        begin
            pix = '0;
        end
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        alpha_next  = alpha_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (acc)
        begin
            if (ctl.has_result && ctl.done)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (32'(col_reg) + 32'd1 >= 32'(width_reg))
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        if (cfg_we)
        begin
            case (cfg.index)
                bblur_pkg::REG_FRAME_WIDTH:
                begin
                    width_next = bblur_pkg::clamp_size(cfg.data, MAX_WIDTH);
                    col_next   = '0;
                    row_next   = '0;
                end
                bblur_pkg::REG_FRAME_HEIGHT:
                begin
                    height_next = bblur_pkg::clamp_size(cfg.data, MAX_HEIGHT);
                    col_next    = '0;
                    row_next    = '0;
                end
                bblur_pkg::REG_ALPHA_VALUE:
                begin
                    alpha_next = cfg.data[bblur_pkg::CHAN_W-1:0];
                end
                default:
                begin
                    alpha_next = alpha_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bblur_pkg::clamp_size(bblur_pkg::RST_WIDTH, MAX_WIDTH);
            height_reg <= bblur_pkg::clamp_size(bblur_pkg::RST_HEIGHT, MAX_HEIGHT);
            alpha_reg  <= bblur_pkg::RST_ALPHA;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            alpha_reg  <= alpha_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    `BBLUR_ASSERT_ALWAYS(a_width_range, clk, rst_n,
        (width_reg != '0) && (32'(width_reg) <= MAX_WIDTH))
    `BBLUR_ASSERT_ALWAYS(a_height_range, clk, rst_n,
        (height_reg != '0) && (32'(height_reg) <= MAX_HEIGHT))
    `BBLUR_ASSERT_ALWAYS(a_col_in_row, clk, rst_n, 32'(col_reg) < 32'(width_reg))
    `BBLUR_ASSERT_ALWAYS(a_row_bound, clk, rst_n,
        32'(row_reg) <= 32'(height_reg) + 32'd1)
    `BBLUR_ASSERT_NEXT(a_frame_wrap, clk, rst_n, acc && ctl.has_result && ctl.done,
        (col_reg == '0) && (row_reg == '0))

endmodule

// ===== design/bblur_line_mem.sv =====
// Line store of the box blur: one entry per column holding the pixels of the
// two previous rows. Synchronous read: the read word is registered. Depends on bblur_pkg.
module bblur_line_mem #(
    parameter int MAX_WIDTH = bblur_pkg::DEF_MAX_WIDTH
) (
    input  logic                             clk,
    input  logic                             rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
    output logic [bblur_pkg::LINE_W-1:0]     rd_data,
    input  logic                             wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
    input  logic [bblur_pkg::LINE_W-1:0]     wr_data
);

    logic [bblur_pkg::LINE_W-1:0] mem [MAX_WIDTH];
    logic [bblur_pkg::LINE_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read word holds while no new read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== design/bblur_window.sv =====
// Read-modify-write stage of the line store, the 3x3 window and the masked
// channel sums. Depends on bblur_pkg; drives the line store write port.
module bblur_window #(
    parameter int MAX_WIDTH = bblur_pkg::DEF_MAX_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             acc,
    input  bblur_pkg::bblur_ctl_t            ctl_in,
    input  logic [bblur_pkg::RGB_W-1:0]      pix_in,
    input  logic [$clog2(MAX_WIDTH)-1:0]     addr_in,
    output logic                             take_ok,
    input  logic                             out_free,
    output bblur_pkg::bblur_sums_t           sums,
    input  logic [bblur_pkg::LINE_W-1:0]     rd_data,
    output logic                             wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
    output logic [bblur_pkg::LINE_W-1:0]     wr_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RGB_W = bblur_pkg::RGB_W;
    localparam int SUM_W = bblur_pkg::SUM_W;

    logic                       s1_valid_reg, s1_valid_next;
    bblur_pkg::bblur_ctl_t      s1_ctl_reg;
    logic [RGB_W-1:0]           s1_pix_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic                       fwd_hit_reg;
    logic [bblur_pkg::LINE_W-1:0] fwd_data_reg;
    logic                       s1_adv;
    logic [bblur_pkg::LINE_W-1:0] line_word;
    logic [RGB_W-1:0]           top_pix;
    logic [RGB_W-1:0]           mid_pix;

    logic [RGB_W-1:0]           win_reg  [3][3];
    logic [RGB_W-1:0]           win_next [3][3];

    logic [2:0]                 col_use;
    logic [2:0]                 row_use;
    logic [SUM_W-1:0]           sum_r, sum_g, sum_b;

    logic                       s2_valid_reg, s2_valid_next;
    logic [SUM_W-1:0]           s2_r_reg, s2_g_reg, s2_b_reg;
    logic                       s2_done_reg;
    logic                       s2_free;

    assign s2_free = !s2_valid_reg || out_free;
    assign s1_adv  = s1_valid_reg && (!s1_ctl_reg.has_result || s2_free);
    assign take_ok = !s1_valid_reg || s1_adv;

    // A read issued in the same cycle as a write to the same column sees the
    // old word, so that write is captured and used instead.
    assign line_word = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign top_pix   = line_word[bblur_pkg::LINE_W-1:RGB_W];
    assign mid_pix   = line_word[RGB_W-1:0];

    assign wr_en   = s1_adv;
    assign wr_addr = s1_addr_reg;
    assign wr_data = {mid_pix, s1_pix_reg};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[c][r] = win_reg[c + 1][r];
            end
        end
        win_next[2][0] = top_pix;
        win_next[2][1] = mid_pix;
        win_next[2][2] = s1_pix_reg;
    end

    always_comb
    begin
        col_use = {s1_ctl_reg.right_ok, 1'b1, s1_ctl_reg.left_ok};
        row_use = {s1_ctl_reg.bot_ok, 1'b1, s1_ctl_reg.top_ok};
        sum_r   = '0;
        sum_g   = '0;
        sum_b   = '0;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (col_use[c] && row_use[r])
                begin
                    sum_r = sum_r + SUM_W'(win_next[c][r][23:16]);
                    sum_g = sum_g + SUM_W'(win_next[c][r][15:8]);
                    sum_b = sum_b + SUM_W'(win_next[c][r][7:0]);
                end
            end
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s1_adv && s1_ctl_reg.has_result)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            win_reg      <= '{default: '0};
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (s1_adv)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_ctl_reg   <= ctl_in;
            s1_pix_reg   <= pix_in;
            s1_addr_reg  <= addr_in;
            fwd_hit_reg  <= wr_en && (wr_addr == addr_in);
            fwd_data_reg <= wr_data;
        end
        if (s1_adv && s1_ctl_reg.has_result)
        begin
            s2_r_reg    <= sum_r;
            s2_g_reg    <= sum_g;
            s2_b_reg    <= sum_b;
            s2_done_reg <= s1_ctl_reg.done;
        end
    end

    always_comb
    begin
        sums.valid = s2_valid_reg;
        sums.sum_r = s2_r_reg;
        sums.sum_g = s2_g_reg;
        sums.sum_b = s2_b_reg;
        sums.done  = s2_done_reg;
    end

endmodule
